[design/rtsf_pkg.sv]
// Package for the radar target sector filter.
// Holds the parser and sequencer state types, link byte codes and sector geometry.
// No dependencies.
package rtsf_pkg;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SKIP,
        PH_HDR2,
        PH_BODY
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_LOAD,
        ST_DIV
    } state_t;

    localparam logic       CFG_FRAMES = 1'b0;
    localparam logic       CFG_THRESH = 1'b1;

    localparam logic [7:0] BYTE_SKIP  = 8'h0B;
    localparam logic [7:0] BYTE_HDR1  = 8'h0C;
    localparam logic [7:0] BYTE_HDR2  = 8'h07;

    localparam logic [2:0] LAST_INDEX = 3'd7;
    localparam logic [2:0] DIST_HI_INDEX = 3'd2;
    localparam logic [2:0] DIST_LO_INDEX = 3'd3;
    localparam logic [2:0] ANGLE_INDEX   = 3'd4;

    localparam logic [15:0] SUM_INIT  = 16'hFFFF;
    localparam logic [15:0] MEAN_NONE = 16'hFFFF;
    localparam logic [7:0]  ANGLE_BIAS = 8'd90;

    localparam int          NUM_SECT  = 5;
    localparam logic [2:0]  SECT_LAST = 3'd4;
    localparam logic [2:0]  SECT_NONE = 3'd5;
    localparam int          SECT_LO   = -50;
    localparam int          SECT_SPAN = 20;

    localparam logic [7:0] FRAMES_RESET = 8'd10;
    localparam logic [7:0] THRESH_RESET = 8'd3;

    // Lowest sector whose closed interval holds the angle, SECT_NONE if none.
    function automatic logic [2:0] sector_of(input logic signed [7:0] ang);
        logic [2:0]        sect;
        logic signed [9:0] ang_x;
        logic signed [9:0] lo;
        logic signed [9:0] hi;
        sect  = SECT_NONE;
        ang_x = {{2{ang[7]}}, ang};
        for (int i = NUM_SECT - 1; i >= 0; i--) begin
            lo = 10'(SECT_LO + SECT_SPAN * i);
            hi = 10'(SECT_LO + SECT_SPAN * (i + 1));
            if (ang_x >= lo && ang_x <= hi) begin
                sect = 3'(i);
            end
        end
        return sect;
    endfunction

endpackage

[design/radar_target_sector_filter_top.sv]
// Radar target sector filter, top level.
// Parses the radar byte stream, bins targets into five angle sectors and
// averages distances per window with one shared restoring divider. Uses rtsf_pkg.
//
//  channel   | dir | handshake                    | payload
//  ----------+-----+------------------------------+-------------------------------------
//  s_axis    | in  | tvalid/tready                | tdata[7:0] = rx_byte
//  m_axis    | out | tvalid/tready                | tuser = window_done, tdata = means,
//            |     |                              |   hit_sector, hit_distance
//  cfg       | in  | cfg_we, no back-pressure     | cfg_addr selects register, cfg_wdata
//
// Sequencing: a byte that does not end a target frame is taken while idle. The last
// frame byte runs a count step; when it closes a window, the one divider then runs
// a load plus 16 quotient steps for each sector, and no byte is taken meanwhile.
// Reset (aresetn low, synchronous): parser idle, window counts zero, sums 0xFFFF,
// registers back to 10 and 3.
// Stalls: a held result blocks only a byte that would finish the next frame;
// other bytes keep flowing while m_axis waits.
module radar_target_sector_filter_top (
    input  logic         aclk,
    input  logic         aresetn,
    // input request
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
    // result request
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,   // [15:0] mean_0, [31:16] mean_1, [47:32] mean_2,
                                         // [63:48] mean_3, [79:64] mean_4,
                                         // [82:80] hit_sector, [98:83] hit_distance,
                                         // [103:99] zero
    output logic         m_axis_tuser,   // [0] window_done
    // configuration writes
    input  logic         cfg_we,
    input  logic         cfg_addr,
    input  logic [7:0]   cfg_wdata
);

    // configuration
    logic [7:0] frames_cfg_reg;
    logic [7:0] thresh_cfg_reg;

    // parser
    rtsf_pkg::phase_t phase_reg;
    logic [2:0]       pay_idx_reg;
    logic [7:0]       pay_reg [3];

    // window accumulators
    logic [7:0]  win_frames_reg;
    logic [7:0]  hits_reg [rtsf_pkg::NUM_SECT];
    logic [15:0] sums_reg [rtsf_pkg::NUM_SECT];

    // sequencer and shared divider
    rtsf_pkg::state_t state_reg;
    rtsf_pkg::state_t state_next;
    logic [2:0]  sect_idx_reg;
    logic [3:0]  bit_cnt_reg;
    logic [7:0]  rem_reg;
    logic [15:0] quo_reg;
    logic [7:0]  div_reg;
    logic [7:0]  thresh_reg;

    // result registers
    logic        m_valid_reg;
    logic        done_reg;
    logic [2:0]  hit_sect_reg;
    logic [15:0] hit_dist_reg;
    logic [15:0] mean_reg [rtsf_pkg::NUM_SECT];

    // frame decode
    logic              in_fire;
    logic              frame_end;
    logic [15:0]       tgt_dist;
    logic signed [7:0] angle;
    logic [2:0]        sect;
    logic [7:0]        frames_inc;
    logic [7:0]        div_eff;
    logic              win_close;

    // divider step
    logic [8:0]  trial;
    logic        take;
    logic [7:0]  rem_next;
    logic [15:0] quo_next;
    logic        last_bit;
    logic        last_sect;

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign frame_end = (phase_reg == rtsf_pkg::PH_BODY) && (pay_idx_reg == rtsf_pkg::LAST_INDEX);

    assign tgt_dist   = {pay_reg[0], pay_reg[1]};
    // 2*byte4 - 90, kept to 8 bits and read as signed
    assign angle      = signed'({pay_reg[2][6:0], 1'b0} - rtsf_pkg::ANGLE_BIAS);
    assign sect       = rtsf_pkg::sector_of(angle);
    assign frames_inc = win_frames_reg + 8'd1;
    assign div_eff    = (frames_cfg_reg == 8'd0) ? 8'd1 : frames_cfg_reg;
    assign win_close  = (frames_inc >= div_eff);

    // one restoring step: shift in the next dividend bit, subtract when it fits
    assign trial     = {rem_reg, quo_reg[15]};
    assign take      = (trial >= {1'b0, div_reg});
    assign rem_next  = take ? 8'(trial - {1'b0, div_reg}) : trial[7:0];
    assign quo_next  = {quo_reg[14:0], take};
    assign last_bit  = (bit_cnt_reg == 4'd15);
    assign last_sect = (sect_idx_reg == rtsf_pkg::SECT_LAST);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rtsf_pkg::ST_IDLE: begin
                if (in_fire && frame_end) begin
                    state_next = rtsf_pkg::ST_ACCUM;
                end
            end
            rtsf_pkg::ST_ACCUM: begin
                state_next = win_close ? rtsf_pkg::ST_LOAD : rtsf_pkg::ST_IDLE;
            end
            rtsf_pkg::ST_LOAD: begin
                state_next = rtsf_pkg::ST_DIV;
            end
            rtsf_pkg::ST_DIV: begin
                if (last_bit) begin
                    state_next = last_sect ? rtsf_pkg::ST_IDLE : rtsf_pkg::ST_LOAD;
                end
            end
            default: state_next = rtsf_pkg::ST_IDLE;
        endcase
    end

    // outputs: take bytes while idle, but hold a frame's last byte until the
    // previous result has left
    always_comb begin
        case (state_reg)
            rtsf_pkg::ST_IDLE: s_axis_tready = !(m_valid_reg && frame_end);
            default:           s_axis_tready = 1'b0;
        endcase
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = done_reg;
    assign m_axis_tdata  = {5'd0, hit_dist_reg, hit_sect_reg,
                            done_reg ? mean_reg[4] : 16'd0,
                            done_reg ? mean_reg[3] : 16'd0,
                            done_reg ? mean_reg[2] : 16'd0,
                            done_reg ? mean_reg[1] : 16'd0,
                            done_reg ? mean_reg[0] : 16'd0};

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frames_cfg_reg <= rtsf_pkg::FRAMES_RESET;
            thresh_cfg_reg <= rtsf_pkg::THRESH_RESET;
            phase_reg      <= rtsf_pkg::PH_IDLE;
            pay_idx_reg    <= 3'd0;
            state_reg      <= rtsf_pkg::ST_IDLE;
            m_valid_reg    <= 1'b0;
            win_frames_reg <= 8'd0;
            for (int i = 0; i < rtsf_pkg::NUM_SECT; i++) begin
                hits_reg[i] <= 8'd0;
                sums_reg[i] <= rtsf_pkg::SUM_INIT;
            end
        end else begin
            state_reg <= state_next;

            if (cfg_we) begin
                case (cfg_addr)
                    rtsf_pkg::CFG_FRAMES: frames_cfg_reg <= cfg_wdata;
                    rtsf_pkg::CFG_THRESH: thresh_cfg_reg <= cfg_wdata;
                    default: ;
                endcase
            end

            // parse the byte stream
            if (in_fire) begin
                case (phase_reg)
                    rtsf_pkg::PH_IDLE: begin
                        if (s_axis_tdata == rtsf_pkg::BYTE_SKIP) begin
                            phase_reg <= rtsf_pkg::PH_SKIP;
                        end else if (s_axis_tdata == rtsf_pkg::BYTE_HDR1) begin
                            phase_reg <= rtsf_pkg::PH_HDR2;
                        end
                    end
                    rtsf_pkg::PH_SKIP: phase_reg <= rtsf_pkg::PH_IDLE;
                    rtsf_pkg::PH_HDR2: begin
                        pay_idx_reg <= 3'd0;
                        phase_reg   <= (s_axis_tdata == rtsf_pkg::BYTE_HDR2) ?
                                       rtsf_pkg::PH_BODY : rtsf_pkg::PH_IDLE;
                    end
                    default: begin
                        if (frame_end) begin
                            pay_idx_reg <= 3'd0;
                            phase_reg   <= rtsf_pkg::PH_IDLE;
                        end else begin
                            pay_idx_reg <= pay_idx_reg + 3'd1;
                        end
                    end
                endcase
            end

            // drop the result once taken
            if (m_valid_reg && m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end

            // count the target into its sector
            if (state_reg == rtsf_pkg::ST_ACCUM) begin
                if (sect != rtsf_pkg::SECT_NONE) begin
                    hits_reg[sect] <= hits_reg[sect] + 8'd1;
                    sums_reg[sect] <= sums_reg[sect] + tgt_dist;
                end
                win_frames_reg <= frames_inc;
                if (!win_close) begin
                    m_valid_reg <= 1'b1;
                end
            end

            // after the last sector mean, clear the window and present the result
            if (state_reg == rtsf_pkg::ST_DIV && last_bit && last_sect) begin
                win_frames_reg <= 8'd0;
                for (int i = 0; i < rtsf_pkg::NUM_SECT; i++) begin
                    hits_reg[i] <= 8'd0;
                    sums_reg[i] <= rtsf_pkg::SUM_INIT;
                end
                m_valid_reg <= 1'b1;
            end
        end
    end

    // payload and datapath registers
    always_ff @(posedge aclk) begin
        if (in_fire && phase_reg == rtsf_pkg::PH_BODY) begin
            case (pay_idx_reg)
                rtsf_pkg::DIST_HI_INDEX: pay_reg[0] <= s_axis_tdata;
                rtsf_pkg::DIST_LO_INDEX: pay_reg[1] <= s_axis_tdata;
                rtsf_pkg::ANGLE_INDEX:   pay_reg[2] <= s_axis_tdata;
                default: ;
            endcase
        end

        case (state_reg)
            rtsf_pkg::ST_ACCUM: begin
                hit_sect_reg <= sect;
                hit_dist_reg <= tgt_dist;
                done_reg     <= win_close;
                div_reg      <= div_eff;
                thresh_reg   <= thresh_cfg_reg;
                sect_idx_reg <= 3'd0;
            end
            rtsf_pkg::ST_LOAD: begin
                rem_reg     <= 8'd0;
                quo_reg     <= sums_reg[sect_idx_reg];
                bit_cnt_reg <= 4'd0;
            end
            rtsf_pkg::ST_DIV: begin
                rem_reg     <= rem_next;
                quo_reg     <= quo_next;
                bit_cnt_reg <= bit_cnt_reg + 4'd1;
                if (last_bit) begin
                    mean_reg[sect_idx_reg] <= (hits_reg[sect_idx_reg] >= thresh_reg) ?
                                              quo_next : rtsf_pkg::MEAN_NONE;
                    sect_idx_reg <= sect_idx_reg + 3'd1;
                end
            end
            default: ;
        endcase
    end

    // the divider remainder always stays below the divisor
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == rtsf_pkg::ST_DIV |-> rem_reg < div_reg)
        else $error("divider remainder not below divisor");

    // a result appears only out of the count step or the last divider step
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == rtsf_pkg::ST_ACCUM ||
                                $past(state_reg) == rtsf_pkg::ST_DIV))
        else $error("result raised outside the sequencer");

    // a window-closing result leaves the window counter cleared
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && done_reg |-> win_frames_reg == 8'd0)
        else $error("window not cleared after means were reported");

    // no frame completes while an earlier result still waits
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> state_reg == rtsf_pkg::ST_IDLE)
        else $error("sequencer busy while a result is held");

    // sector index is a sector or the no-sector code
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> hit_sect_reg <= rtsf_pkg::SECT_NONE)
        else $error("hit sector out of range");

endmodule

[tb/rtsf_report_checker.sv]
// Frame report checker for the radar target sector filter testbench.
// Watches the byte, result and register ports, predicts every target frame
// report and compares it field by field. Depends on rtsf_pkg.
module rtsf_report_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,    // [7:0] rx_byte
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [103:0] m_axis_tdata,    // mean_0..mean_4, hit_sector, hit_distance, zero
    input  logic         m_axis_tuser,    // [0] window_done
    input  logic         cfg_we,
    input  logic         cfg_addr,
    input  logic [7:0]   cfg_wdata,
    output int           fail_count,
    output int           open_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic             window_done;
        logic [4:0][15:0] means;
        logic [2:0]       sector;
        logic [15:0]      distance;
    } frame_report_t;

    frame_report_t report_q[$];

    logic [7:0]       frames_cfg = rtsf_pkg::FRAMES_RESET;
    logic [7:0]       thresh_cfg = rtsf_pkg::THRESH_RESET;
    rtsf_pkg::phase_t parse_ph   = rtsf_pkg::PH_IDLE;
    logic [2:0]       body_idx   = '0;
    logic [7:0]       body_bytes [3];
    logic [7:0]       frame_cnt  = '0;
    logic [7:0]       hits [5];
    logic [15:0]      sums [5];
    int               errs = 0;

    task automatic clear_window();
        frame_cnt = '0;
        for (int i = 0; i < 5; i++) begin
            hits[i] = '0;
            sums[i] = 16'hFFFF;
        end
    endtask

    // Bin the finished target, report it and close the window when it is full.
    task automatic close_frame();
        logic [15:0]   tgt_dist;
        logic [7:0]    raw;
        int            ang;
        logic [2:0]    sect;
        logic [7:0]    div;
        frame_report_t rep;
        tgt_dist = {body_bytes[0], body_bytes[1]};
        raw  = {body_bytes[2][6:0], 1'b0} - 8'd90;
        ang  = raw[7] ? int'(raw) - 256 : int'(raw);
        sect = rtsf_pkg::SECT_NONE;
        for (int i = 4; i >= 0; i--) begin
            if (ang >= -50 + 20 * i && ang <= -30 + 20 * i) begin
                sect = 3'(i);
            end
        end
        if (sect != rtsf_pkg::SECT_NONE) begin
            hits[sect] = hits[sect] + 8'd1;
            sums[sect] = sums[sect] + tgt_dist;
        end
        frame_cnt    = frame_cnt + 8'd1;
        rep          = '0;
        rep.sector   = sect;
        rep.distance = tgt_dist;
        div = (frames_cfg == 8'd0) ? 8'd1 : frames_cfg;
        if (frame_cnt >= div) begin
            rep.window_done = 1'b1;
            for (int i = 0; i < 5; i++) begin
                rep.means[i] = (hits[i] >= thresh_cfg) ? sums[i] / {8'd0, div}
                                                       : rtsf_pkg::MEAN_NONE;
            end
            clear_window();
        end
        report_q.push_back(rep);
    endtask

    task automatic track_byte(input logic [7:0] b);
        case (parse_ph)
            rtsf_pkg::PH_IDLE: begin
                if (b == rtsf_pkg::BYTE_SKIP) begin
                    parse_ph = rtsf_pkg::PH_SKIP;
                end else if (b == rtsf_pkg::BYTE_HDR1) begin
                    parse_ph = rtsf_pkg::PH_HDR2;
                end
            end
            rtsf_pkg::PH_SKIP: parse_ph = rtsf_pkg::PH_IDLE;
            rtsf_pkg::PH_HDR2: begin
                if (b == rtsf_pkg::BYTE_HDR2) begin
                    parse_ph = rtsf_pkg::PH_BODY;
                    body_idx = '0;
                end else begin
                    parse_ph = rtsf_pkg::PH_IDLE;
                end
            end
            default: begin
                if (body_idx >= rtsf_pkg::DIST_HI_INDEX &&
                    body_idx <= rtsf_pkg::ANGLE_INDEX) begin
                    body_bytes[int'(body_idx) - 2] = b;
                end
                if (body_idx == rtsf_pkg::LAST_INDEX) begin
                    body_idx = '0;
                    parse_ph = rtsf_pkg::PH_IDLE;
                    close_frame();
                end else begin
                    body_idx = body_idx + 3'd1;
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            errs++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : watch
        frame_report_t want;
        if (!aresetn) begin
            frames_cfg = rtsf_pkg::FRAMES_RESET;
            thresh_cfg = rtsf_pkg::THRESH_RESET;
            parse_ph   = rtsf_pkg::PH_IDLE;
            body_idx   = '0;
            clear_window();
            report_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    rtsf_pkg::CFG_FRAMES: frames_cfg = cfg_wdata;
                    rtsf_pkg::CFG_THRESH: thresh_cfg = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                track_byte(s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (report_q.size() == 0) begin
                    errs++;
                    $display("%0t: unexpected result: expected none, actual tdata %h tuser %b",
                             $time, m_axis_tdata, m_axis_tuser);
                end else begin
                    want = report_q.pop_front();
                    check_field("window_done", 16'(want.window_done), 16'(m_axis_tuser));
                    for (int i = 0; i < 5; i++) begin
                        check_field($sformatf("mean_%0d", i), want.means[i],
                                    m_axis_tdata[16 * i +: 16]);
                    end
                    check_field("hit_sector", 16'(want.sector), 16'(m_axis_tdata[82:80]));
                    check_field("hit_distance", want.distance, m_axis_tdata[98:83]);
                    check_field("pad bits", 16'd0, 16'(m_axis_tdata[103:99]));
                end
            end
        end
        fail_count <= errs;
        open_count <= report_q.size();
    end

endmodule

[tb/radar_target_sector_filter_top_tb.sv]
// Testbench top for the radar target sector filter: drives radar link bytes,
// register writes and result back-pressure, and gives the verdict.
// Depends on rtsf_pkg, radar_target_sector_filter_top and rtsf_report_checker.
module radar_target_sector_filter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic         aclk          = 1'b0;
    logic         aresetn       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata  = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         cfg_we        = 1'b0;
    logic         cfg_addr      = rtsf_pkg::CFG_FRAMES;
    logic [7:0]   cfg_wdata     = '0;

    int   fail_count;
    int   open_count;
    int   bytes_sent  = 0;
    int   frames_sent = 0;
    // Random idling on both channels; cleared for one stretch of the run.
    logic idle_on     = 1'b1;

    radar_target_sector_filter_top u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    rtsf_report_checker u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .open_count    (open_count)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Stall the result channel at random, about 19 percent of the time, while idling is on.
    always @(posedge aclk) begin
        m_axis_tready <= !idle_on || ($urandom_range(0, 99) >= 19);
    end

    // Offer one byte, idling first at random, and hold it until the request is taken.
    // Valid stays high into the next byte unless an idle cycle follows.
    task automatic send_byte(input logic [7:0] b);
        while (idle_on && $urandom_range(0, 99) < 19) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge aclk);
        while (!s_axis_tready) begin
            @(posedge aclk);
        end
        bytes_sent++;
    endtask

    // Send a complete target frame: two header bytes and eight body bytes.
    // With hdr_fill, pad the unused body bytes with link codes so that the
    // parser must not read them as headers.
    task automatic send_frame(input logic [15:0] tgt_dist, input logic [7:0] ang_byte,
                              input logic hdr_fill);
        logic [7:0] b;
        send_byte(rtsf_pkg::BYTE_HDR1);
        send_byte(rtsf_pkg::BYTE_HDR2);
        for (int idx = 0; idx < 8; idx++) begin
            if (idx == rtsf_pkg::DIST_HI_INDEX) begin
                b = tgt_dist[15:8];
            end else if (idx == rtsf_pkg::DIST_LO_INDEX) begin
                b = tgt_dist[7:0];
            end else if (idx == rtsf_pkg::ANGLE_INDEX) begin
                b = ang_byte;
            end else if (hdr_fill) begin
                b = idx[0] ? rtsf_pkg::BYTE_SKIP : rtsf_pkg::BYTE_HDR1;
            end else begin
                b = 8'($urandom_range(0, 255));
            end
            send_byte(b);
        end
        frames_sent++;
    endtask

    // Mostly well-formed frames with random content; the rest is skip pairs,
    // broken headers and loose bytes.
    task automatic random_traffic(input int n);
        int          stop_at;
        int          pick;
        logic [15:0] tgt_dist;
        logic [7:0]  ang_byte;
        logic [7:0]  b;
        stop_at = bytes_sent + n;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 72) begin
                case ($urandom_range(0, 9))
                    0:       tgt_dist = 16'hFFFF;
                    1:       tgt_dist = 16'h0000;
                    default: tgt_dist = 16'($urandom);
                endcase
                // Angle byte 20..70 spans the sectors; widen a little to hit the edges.
                ang_byte = $urandom_range(0, 1) ? 8'($urandom_range(15, 75))
                                                : 8'($urandom_range(0, 255));
                send_frame(tgt_dist, ang_byte, $urandom_range(0, 7) == 0);
            end else if (pick < 80) begin
                send_byte(rtsf_pkg::BYTE_SKIP);
                send_byte(8'($urandom_range(0, 255)));
            end else if (pick < 88) begin
                b = 8'($urandom_range(0, 255));
                if (b == rtsf_pkg::BYTE_HDR2) begin
                    b = rtsf_pkg::BYTE_HDR1;
                end
                send_byte(rtsf_pkg::BYTE_HDR1);
                send_byte(b);
            end else begin
                send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Drop valid, drain every pending report, then let a window-end division finish.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (open_count != 0) begin
            @(posedge aclk);
        end
        repeat (100) @(posedge aclk);
    endtask

    task automatic write_reg(input logic addr, input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    task automatic set_window(input logic [7:0] frames, input logic [7:0] thresh);
        write_reg(rtsf_pkg::CFG_FRAMES, frames);
        write_reg(rtsf_pkg::CFG_THRESH, thresh);
        cfg_we <= 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at the reset settings.
        // A skip byte swallows a following header byte.
        send_byte(rtsf_pkg::BYTE_SKIP);
        send_byte(rtsf_pkg::BYTE_HDR1);
        // Bad second header byte: consumed, back to idle.
        send_byte(rtsf_pkg::BYTE_HDR1);
        send_byte(rtsf_pkg::BYTE_SKIP);
        // Largest distance at the low edge of sector 0.
        send_frame(16'hFFFF, 8'd20, 1'b0);
        // Zero distance at the high edge of sector 4, body full of link codes.
        send_frame(16'h0000, 8'd70, 1'b1);
        settle();

        // One frame per window, every sector confirmed.
        set_window(8'd1, 8'd0);
        random_traffic(60);
        settle();

        // Zero frame count acts as one; no sector can be confirmed.
        set_window(8'd0, 8'd255);
        random_traffic(60);
        settle();

        // Longest window, no idling on either side; the window stays open.
        idle_on <= 1'b0;
        set_window(8'd255, 8'd1);
        random_traffic(50);
        settle();
        idle_on <= 1'b1;

        // Lower the frame count mid-window: the next frame closes it.
        set_window(8'd2, 8'd2);
        random_traffic(80);
        settle();

        set_window(8'd5, 8'd1);
        random_traffic(100);
        settle();

        set_window(8'd10, 8'd3);
        while (bytes_sent < 550 || frames_sent < 45) begin
            random_traffic(40);
        end
        settle();

        if (fail_count == 0) begin
            $display("radar_target_sector_filter_top_tb OK");
        end else begin
            $display("radar_target_sector_filter_top_tb NOT OK");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #2_000_000;
        $display("radar_target_sector_filter_top_tb NOT OK");
        $finish;
    end

endmodule
